// ===== rtl/core/pts_pkg.sv =====
// Package for the priority thread scheduler: operation, status and state codes.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package pts_pkg;

  localparam int TID_W = 4;

  // Requested operation.
  localparam logic [2:0] OP_MAKE_READY = 3'd0;
  localparam logic [2:0] OP_SLEEP      = 3'd1;
  localparam logic [2:0] OP_TICK       = 3'd2;
  localparam logic [2:0] OP_TERMINATE  = 3'd3;
  localparam logic [2:0] OP_BLOCK      = 3'd4;

  // Per-thread state in the thread table.
  localparam logic [1:0] TS_DEAD  = 2'd0;
  localparam logic [1:0] TS_READY = 2'd1;
  localparam logic [1:0] TS_WAIT  = 2'd2;
  localparam logic [1:0] TS_RUN   = 2'd3;

  // Result status.
  localparam logic [1:0] RS_OK      = 2'd0;
  localparam logic [1:0] RS_FULL    = 2'd1;
  localparam logic [1:0] RS_INVALID = 2'd2;

  // Queue levels.
  localparam logic [1:0] Q_LOW    = 2'd0;
  localparam logic [1:0] Q_NORMAL = 2'd1;
  localparam logic [1:0] Q_HIGH   = 2'd2;

  // Register byte address.
  localparam logic [2:0] ADDR_IDLE_THREAD = 3'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MR,
    S_SLP,
    S_TICK,
    S_TRD,
    S_TREQ,
    S_TERM,
    S_TNEXT,
    S_SCAN,
    S_DISP,
    S_DISP2,
    S_DISP3
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/pts_apb_regs.sv =====
// APB register block of the scheduler: holds the idle thread number.
// Depends on pts_pkg.
`default_nettype none

module pts_apb_regs (
  input  wire  logic                      clk,
  input  wire  logic                      rst,
  input  wire  logic                      psel,
  input  wire  logic                      penable,
  input  wire  logic                      pwrite,
  input  wire  logic [2:0]                paddr,
  input  wire  logic [31:0]               pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [pts_pkg::TID_W-1:0]       idle_thread
);
  import pts_pkg::*;

  // The single register is written on the access phase of a write request.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_thread <= TID_W'(1);
    end else if (psel && penable && pwrite && paddr == ADDR_IDLE_THREAD) begin
      idle_thread <= pwdata[TID_W-1:0];
    end
  end

  // Reads return the register, zero elsewhere.
  always_comb begin
    pready = 1'b1;
    prdata = '0;
    if (paddr == ADDR_IDLE_THREAD) begin
      prdata = 32'(idle_thread);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pts_fifo_ram.sv =====
// Ready queue storage: one synchronous RAM holding the three queue rings.
// Contents are undefined until written. Depends on pts_pkg.
`default_nettype none

module pts_fifo_ram #(
  parameter int DEPTH = 48,
  parameter int AW    = 6
) (
  input  wire  logic                        clk,
  input  wire  logic                        we,
  input  wire  logic [AW-1:0]               waddr,
  input  wire  logic [pts_pkg::TID_W-1:0]   wdata,
  input  wire  logic [AW-1:0]               raddr,
  output logic [pts_pkg::TID_W-1:0]         rdata
);
  import pts_pkg::*;

  logic [TID_W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/pts_thread_table.sv =====
// Thread table: one synchronous RAM entry per thread {state, priority, sleep}.
// Valid bits make unwritten entries read as zero after reset. Depends on pts_pkg.
`default_nettype none

module pts_thread_table #(
  parameter int DEPTH = 16,
  parameter int IW    = 4,
  parameter int EW    = 20
) (
  input  wire  logic          clk,
  input  wire  logic          rst,
  input  wire  logic          we,
  input  wire  logic [IW-1:0] waddr,
  input  wire  logic [EW-1:0] wdata,
  input  wire  logic [IW-1:0] raddr,
  output logic [EW-1:0]       rdata
);
  import pts_pkg::*;

  logic [EW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [EW-1:0]    mem_q;
  logic             valid_q;

  // Entry storage with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // Valid bits are cleared at reset and set by the first write of an entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      valid_q <= valid[raddr];
    end
  end

  assign rdata = valid_q ? mem_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/priority_thread_scheduler_unit.sv =====
// Top level of the priority thread scheduler: sequencer over the thread table
// and the ready queue RAM. Depends on pts_pkg, pts_apb_regs, pts_fifo_ram and
// pts_thread_table.
// Terminate of a thread that is not running scans each of the three queues, and
// tick walks the thread table, one entry per cycle. One request at a time.
// busy is high while a request is at work; done pulses one cycle per result.
// Reset (synchronous) clears the queues and thread table at once; no sweep.
`default_nettype none

module priority_thread_scheduler_unit #(
  parameter int THREAD_COUNT = 16,
  parameter int QUEUE_DEPTH  = 16,
  parameter int TICK_BITS    = 16
) (
  input  wire  logic                      clk,
  input  wire  logic                      rst,
  input  wire  logic                      psel,
  input  wire  logic                      penable,
  input  wire  logic                      pwrite,
  input  wire  logic [2:0]                paddr,
  input  wire  logic [31:0]               pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  wire  logic                      start,
  output logic                            busy,
  input  wire  logic [2:0]                operation,
  input  wire  logic [pts_pkg::TID_W-1:0] thread_id,
  input  wire  logic [1:0]                thread_priority,
  input  wire  logic [15:0]               tick_count,
  output logic                            done,
  output logic [pts_pkg::TID_W-1:0]       running_thread,
  output logic [pts_pkg::TID_W-1:0]       previous_thread,
  output logic                            switched,
  output logic [1:0]                      status
);
  import pts_pkg::*;

  localparam int IW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int FDEPTH = 3 * QUEUE_DEPTH;
  localparam int AW = $clog2(FDEPTH);
  localparam int EW = 4 + TICK_BITS;

  state_t state, state_next;

  logic [TID_W-1:0]     idle_thread;
  logic [TID_W-1:0]     running, running_next;
  logic [TID_W-1:0]     prev, prev_next;
  logic [TID_W-1:0]     tid, tid_next;
  logic [1:0]           pri, pri_next;
  logic [1:0]           qsel, qsel_next;
  logic [1:0]           st, st_next;
  logic [TICK_BITS-1:0] sleep_val, sleep_val_next;
  logic [TICK_BITS-1:0] sat_ticks;
  logic [IW-1:0]        idx, idx_next;
  logic [CW-1:0]        kpos, kpos_next;
  logic [CW-1:0]        mpos, mpos_next;
  logic                 fin;

  logic [PW-1:0] head [3];
  logic [PW-1:0] tail [3];
  logic [CW-1:0] count [3];
  logic [PW-1:0] head_next [3];
  logic [PW-1:0] tail_next [3];
  logic [CW-1:0] count_next [3];

  logic          push_en, pop_en;
  logic [1:0]    push_q, pop_q;
  logic [TID_W-1:0] push_id;
  logic          scan_end;
  logic [CW-1:0] scan_cnt;

  logic             tbl_we;
  logic [IW-1:0]    tbl_waddr, tbl_raddr;
  logic [EW-1:0]    tbl_wdata, tbl_rdata;
  logic             fifo_we;
  logic [AW-1:0]    fifo_waddr, fifo_raddr;
  logic [TID_W-1:0] fifo_wdata, fifo_rdata;

  logic [1:0]           e_status, e_pri;
  logic [TICK_BITS-1:0] e_sleep, e_dec;
  logic                 t_ok, run_ok;

  pts_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .idle_thread (idle_thread)
  );

  pts_thread_table #(
    .DEPTH (THREAD_COUNT),
    .IW    (IW),
    .EW    (EW)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  pts_fifo_ram #(
    .DEPTH (FDEPTH),
    .AW    (AW)
  ) u_fifo (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (fifo_raddr),
    .rdata (fifo_rdata)
  );

  // Sleep length saturates to the largest counter value.
  generate
    if (TICK_BITS >= 16) begin : g_sat_wide
      assign sat_ticks = TICK_BITS'(tick_count);
    end else begin : g_sat_narrow
      assign sat_ticks = (|tick_count[15:TICK_BITS]) ? '1 : tick_count[TICK_BITS-1:0];
    end
  endgenerate

  // Address of a slot within one queue ring.
  function automatic logic [AW-1:0] faddr(input logic [1:0] q, input logic [PW-1:0] p);
    faddr = AW'(q) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  // Ring position plus an offset of at most one full ring.
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    wrap_add = PW'(s);
  endfunction

  // Fields of the entry read last cycle.
  assign e_status = tbl_rdata[EW-1:EW-2];
  assign e_pri    = tbl_rdata[EW-3:EW-4];
  assign e_sleep  = tbl_rdata[TICK_BITS-1:0];
  assign e_dec    = e_sleep - TICK_BITS'(1);

  assign t_ok   = 32'(thread_id) < THREAD_COUNT;
  assign run_ok = (running != idle_thread) && (32'(running) < THREAD_COUNT);
  assign busy   = (state != S_IDLE);

  // Occupancy of the selected queue and scan bound.
  always_comb begin
    scan_cnt = '0;
    for (int q = 0; q < 3; q++) begin
      if (qsel == 2'(q)) begin
        scan_cnt = count[q];
      end
    end
  end

  // Sequencer: next state, memory accesses and queue updates.
  always_comb begin
    state_next     = state;
    running_next   = running;
    prev_next      = prev;
    tid_next       = tid;
    pri_next       = pri;
    qsel_next      = qsel;
    st_next        = st;
    sleep_val_next = sleep_val;
    idx_next       = idx;
    kpos_next      = kpos;
    mpos_next      = mpos;
    fin            = 1'b0;
    scan_end       = 1'b0;
    push_en        = 1'b0;
    push_q         = Q_LOW;
    push_id        = '0;
    pop_en         = 1'b0;
    pop_q          = Q_LOW;
    tbl_we         = 1'b0;
    tbl_waddr      = '0;
    tbl_wdata      = '0;
    tbl_raddr      = '0;
    fifo_we        = 1'b0;
    fifo_waddr     = '0;
    fifo_wdata     = '0;
    fifo_raddr     = '0;
    for (int q = 0; q < 3; q++) begin
      head_next[q]  = head[q];
      tail_next[q]  = tail[q];
      count_next[q] = count[q];
    end

    case (state)
      S_IDLE: begin
        if (start) begin
          tid_next       = thread_id;
          pri_next       = thread_priority;
          prev_next      = running;
          st_next        = RS_OK;
          sleep_val_next = (operation == OP_SLEEP) ? sat_ticks : '0;
          case (operation)
            OP_MAKE_READY: begin
              if (!t_ok || thread_priority > Q_HIGH || thread_id == running ||
                  thread_id == idle_thread) begin
                st_next = RS_INVALID;
                fin     = 1'b1;
              end else begin
                tbl_raddr  = IW'(thread_id);
                state_next = S_MR;
              end
            end
            OP_SLEEP, OP_BLOCK: begin
              if (!run_ok || (operation == OP_SLEEP && tick_count == '0)) begin
                st_next = RS_INVALID;
                fin     = 1'b1;
              end else begin
                tbl_raddr  = IW'(running);
                state_next = S_SLP;
              end
            end
            OP_TICK: begin
              tbl_raddr  = '0;
              idx_next   = '0;
              state_next = S_TICK;
            end
            OP_TERMINATE: begin
              if (!t_ok || thread_id == idle_thread) begin
                st_next = RS_INVALID;
                fin     = 1'b1;
              end else begin
                tbl_raddr  = IW'(thread_id);
                state_next = S_TERM;
              end
            end
            default: begin
              st_next = RS_INVALID;
              fin     = 1'b1;
            end
          endcase
        end
      end

      // Make ready: refuse a thread already queued, else push it unless its queue is full.
      S_MR: begin
        qsel_next = pri;
        if (e_status == TS_READY) begin
          st_next    = RS_INVALID;
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          push_en    = 1'b1;
          push_q     = pri;
          push_id    = tid;
          tbl_we     = 1'b1;
          tbl_waddr  = IW'(tid);
          tbl_wdata  = {TS_READY, pri, TICK_BITS'(0)};
          for (int q = 0; q < 3; q++) begin
            if (pri == 2'(q) && count[q] == CW'(QUEUE_DEPTH)) begin
              push_en = 1'b0;
              tbl_we  = 1'b0;
              st_next = RS_FULL;
            end
          end
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end

      // Sleep or block: the running thread waits, then dispatch.
      S_SLP: begin
        tbl_we     = 1'b1;
        tbl_waddr  = IW'(running);
        tbl_wdata  = {TS_WAIT, e_pri, sleep_val};
        state_next = S_DISP;
      end

      // Tick walk: one thread entry per cycle, read of the next one overlapped.
      S_TICK: begin
        if (e_status == TS_WAIT && e_sleep != '0) begin
          tbl_we    = 1'b1;
          tbl_waddr = idx;
          tbl_wdata = {TS_WAIT, e_pri, e_dec};
          if (e_dec == '0) begin
            tbl_wdata = {TS_READY, e_pri, TICK_BITS'(0)};
            push_en   = 1'b1;
            push_q    = e_pri;
            push_id   = TID_W'(idx);
            for (int q = 0; q < 3; q++) begin
              if (e_pri == 2'(q) && count[q] == CW'(QUEUE_DEPTH)) begin
                push_en   = 1'b0;
                tbl_wdata = {TS_WAIT, e_pri, TICK_BITS'(1)};
                st_next   = RS_FULL;
              end
            end
          end
        end
        if (idx != IW'(THREAD_COUNT - 1)) begin
          tbl_raddr = idx + IW'(1);
          idx_next  = idx + IW'(1);
        end else if (run_ok) begin
          state_next = S_TRD;
        end else begin
          state_next = S_DISP;
        end
      end

      // Read the running thread after the walk has written its last entry.
      S_TRD: begin
        tbl_raddr  = IW'(running);
        state_next = S_TREQ;
      end

      // Re-queue the running thread; if its queue is full it keeps running.
      S_TREQ: begin
        push_en    = 1'b1;
        push_q     = e_pri;
        push_id    = running;
        tbl_we     = 1'b1;
        tbl_waddr  = IW'(running);
        tbl_wdata  = {TS_READY, e_pri, e_sleep};
        state_next = S_DISP;
        for (int q = 0; q < 3; q++) begin
          if (e_pri == 2'(q) && count[q] == CW'(QUEUE_DEPTH)) begin
            push_en    = 1'b0;
            tbl_we     = 1'b0;
            st_next    = RS_FULL;
            fin        = 1'b1;
            state_next = S_IDLE;
          end
        end
      end

      // Terminate: the running thread dies and a dispatch follows; any
      // other live thread is removed from every queue.
      S_TERM: begin
        tbl_we    = 1'b1;
        tbl_waddr = IW'(tid);
        tbl_wdata = {TS_DEAD, e_pri, TICK_BITS'(0)};
        if (tid == running) begin
          state_next = S_DISP;
        end else if (e_status == TS_DEAD) begin
          tbl_we     = 1'b0;
          st_next    = RS_INVALID;
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          qsel_next  = Q_LOW;
          state_next = S_TNEXT;
        end
      end

      // Start the scan of the selected queue, or step past an empty one.
      S_TNEXT: begin
        kpos_next = '0;
        mpos_next = '0;
        if (scan_cnt != '0) begin
          for (int q = 0; q < 3; q++) begin
            if (qsel == 2'(q)) begin
              fifo_raddr = faddr(qsel, head[q]);
            end
          end
          state_next = S_SCAN;
        end else if (qsel == Q_HIGH) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          qsel_next = qsel + 2'd1;
        end
      end

      // Compact the queue in place, dropping the terminated thread.
      S_SCAN: begin
        for (int q = 0; q < 3; q++) begin
          if (qsel == 2'(q)) begin
            if (fifo_rdata != tid) begin
              fifo_we    = 1'b1;
              fifo_waddr = faddr(qsel, wrap_add(head[q], mpos));
              fifo_wdata = fifo_rdata;
              mpos_next  = mpos + CW'(1);
            end
            if (kpos + CW'(1) < scan_cnt) begin
              kpos_next  = kpos + CW'(1);
              fifo_raddr = faddr(qsel, wrap_add(head[q], kpos + CW'(1)));
            end else begin
              scan_end      = 1'b1;
              tail_next[q]  = wrap_add(head[q], mpos_next);
              count_next[q] = mpos_next;
            end
          end
        end
        if (scan_end) begin
          if (qsel == Q_HIGH) begin
            fin        = 1'b1;
            state_next = S_IDLE;
          end else begin
            qsel_next  = qsel + 2'd1;
            state_next = S_TNEXT;
          end
        end
      end

      // Dispatch: pop the head of the highest non-empty queue; the idle thread runs if all are empty.
      S_DISP: begin
        if (count[2] != '0) begin
          pop_en = 1'b1;
          pop_q  = Q_HIGH;
        end else if (count[1] != '0) begin
          pop_en = 1'b1;
          pop_q  = Q_NORMAL;
        end else if (count[0] != '0) begin
          pop_en = 1'b1;
          pop_q  = Q_LOW;
        end
        qsel_next = pop_q;
        if (pop_en) begin
          state_next = S_DISP2;
        end else begin
          running_next = idle_thread;
          fin          = 1'b1;
          state_next   = S_IDLE;
        end
      end

      // The popped thread runs; read its entry to keep priority and sleep.
      S_DISP2: begin
        running_next = fifo_rdata;
        tbl_raddr    = IW'(fifo_rdata);
        state_next   = S_DISP3;
      end

      // Mark the new running thread as running.
      S_DISP3: begin
        tbl_we     = 1'b1;
        tbl_waddr  = IW'(running);
        tbl_wdata  = {TS_RUN, e_pri, e_sleep};
        fin        = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Queue pointer updates for a push or a pop.
    for (int q = 0; q < 3; q++) begin
      if (push_en && push_q == 2'(q)) begin
        fifo_we       = 1'b1;
        fifo_waddr    = faddr(push_q, tail[q]);
        fifo_wdata    = push_id;
        tail_next[q]  = wrap_add(tail[q], CW'(1));
        count_next[q] = count[q] + CW'(1);
      end
      if (pop_en && pop_q == 2'(q)) begin
        fifo_raddr    = faddr(pop_q, head[q]);
        head_next[q]  = wrap_add(head[q], CW'(1));
        count_next[q] = count[q] - CW'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      running <= '0;
      done    <= 1'b0;
      for (int q = 0; q < 3; q++) begin
        head[q]  <= '0;
        tail[q]  <= '0;
        count[q] <= '0;
      end
    end else begin
      state   <= state_next;
      running <= running_next;
      done    <= fin;
      for (int q = 0; q < 3; q++) begin
        head[q]  <= head_next[q];
        tail[q]  <= tail_next[q];
        count[q] <= count_next[q];
      end
    end
  end

  // Working registers and result registers.
  always_ff @(posedge clk) begin
    prev      <= prev_next;
    tid       <= tid_next;
    pri       <= pri_next;
    qsel      <= qsel_next;
    st        <= st_next;
    sleep_val <= sleep_val_next;
    idx       <= idx_next;
    kpos      <= kpos_next;
    mpos      <= mpos_next;
    if (fin) begin
      running_thread  <= running_next;
      previous_thread <= prev_next;
      switched        <= (running_next != prev_next);
      status          <= st_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count[0] <= CW'(QUEUE_DEPTH) && count[1] <= CW'(QUEUE_DEPTH) &&
    count[2] <= CW'(QUEUE_DEPTH))
    else $error("ready queue count exceeds its depth");
  a_switched: assert property (@(posedge clk) disable iff (rst)
    done |-> switched == (running_thread != previous_thread))
    else $error("switched flag disagrees with thread numbers");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3)
    else $error("result status has no meaning");
  a_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted request neither finished nor in progress");
`endif

endmodule

`default_nettype wire
